[design/mwf_pkg.sv]
// shared widths, direction codes, register codes and heading helpers for the wall follower
package mwf_pkg;

	localparam int XY_W          = 5;
	localparam int WID_W         = 2;
	localparam int MOVE_W        = 3;
	localparam int APB_AW        = 5;
	localparam int APB_DW        = 32;
	localparam int GRID_SIDE_DEF = 32;
	localparam int WALKERS_DEF   = 4;

	typedef enum logic [MOVE_W-1:0] {
		DIR_WEST  = 3'd0,
		DIR_NORTH = 3'd1,
		DIR_SOUTH = 3'd2,
		DIR_EAST  = 3'd3,
		DIR_NULL  = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		REG_TARGET_X      = 3'd0,
		REG_TARGET_Y      = 3'd1,
		REG_GRID_WIDTH    = 3'd2,
		REG_GRID_HEIGHT   = 3'd3,
		REG_START_HEADING = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [WID_W-1:0] walker_id;
		logic [XY_W-1:0]  prev_x;
		logic [XY_W-1:0]  prev_y;
		logic [XY_W-1:0]  cur_x;
		logic [XY_W-1:0]  cur_y;
	} turn_t;

	function automatic dir_t left_of(input dir_t d);
		dir_t r;
		case (d)
			DIR_WEST:  r = DIR_SOUTH;
			DIR_NORTH: r = DIR_WEST;
			DIR_SOUTH: r = DIR_EAST;
			DIR_EAST:  r = DIR_NORTH;
			default:   r = DIR_NULL;
		endcase
		return r;
	endfunction

	function automatic dir_t right_of(input dir_t d);
		dir_t r;
		case (d)
			DIR_WEST:  r = DIR_NORTH;
			DIR_NORTH: r = DIR_EAST;
			DIR_SOUTH: r = DIR_WEST;
			DIR_EAST:  r = DIR_SOUTH;
			default:   r = DIR_NULL;
		endcase
		return r;
	endfunction

	function automatic dir_t opposite_of(input dir_t d);
		dir_t r;
		case (d)
			DIR_WEST:  r = DIR_EAST;
			DIR_NORTH: r = DIR_SOUTH;
			DIR_SOUTH: r = DIR_NORTH;
			DIR_EAST:  r = DIR_WEST;
			default:   r = DIR_NULL;
		endcase
		return r;
	endfunction

	function automatic dir_t travel_dir(input logic [XY_W-1:0] px, input logic [XY_W-1:0] py,
			input logic [XY_W-1:0] cx, input logic [XY_W-1:0] cy);
		dir_t r;
		if (cy == py && cx < px) begin
			r = DIR_WEST;
		end else if (cx == px && cy < py) begin
			r = DIR_NORTH;
		end else if (cx == px && cy > py) begin
			r = DIR_SOUTH;
		end else if (cy == py && cx > px) begin
			r = DIR_EAST;
		end else begin
			r = DIR_NULL;
		end
		return r;
	endfunction

endpackage

[design/mwf_ifs.sv]
// turn and move channel interfaces of the wall follower
interface mwf_turn_if;
	logic                       valid;
	logic                       ready;
	logic [mwf_pkg::WID_W-1:0]  walker_id;
	logic [mwf_pkg::XY_W-1:0]   prev_x;
	logic [mwf_pkg::XY_W-1:0]   prev_y;
	logic [mwf_pkg::XY_W-1:0]   cur_x;
	logic [mwf_pkg::XY_W-1:0]   cur_y;

	modport source (output valid, walker_id, prev_x, prev_y, cur_x, cur_y, input ready);
	modport sink (input valid, walker_id, prev_x, prev_y, cur_x, cur_y, output ready);
endinterface

interface mwf_move_if;
	logic                       valid;
	logic                       ready;
	logic [mwf_pkg::MOVE_W-1:0] move_dir;

	modport source (output valid, move_dir, input ready);
	modport sink (input valid, move_dir, output ready);
endinterface

[design/maze_wall_follower_step_unit.sv]
// left-hand wall follower: shared wall map, per-walker visited marks and headings
//
//   channel  dir  handshake            payload
//   turn     in   valid/ready          walker_id, prev_x, prev_y, cur_x, cur_y
//   move     out  valid/ready          move_dir
//   apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// after reset a clearing pass zeroes the wall and visited memories, one cell a cycle;
// turns are refused until it ends. a turn is read from memory at its transfer, decided
// the next cycle and lands in the output register; one turn per cycle while the move
// register is free. a blocked walker whose wall also goes into the neighbor cell holds
// the decide stage for a second wall write, since the wall memory has one write port.
// a stalled move register holds the decide stage, which then stops taking turns.
module maze_wall_follower_step_unit #(
	parameter int GRID_SIDE = mwf_pkg::GRID_SIDE_DEF,
	parameter int WALKERS   = mwf_pkg::WALKERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mwf_turn_if.sink                    turn,
	mwf_move_if.source                  move,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mwf_pkg::APB_AW-1:0]  paddr,
	input  logic [mwf_pkg::APB_DW-1:0]  pwdata,
	output logic [mwf_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W = $clog2(CELLS);
	localparam int WIDX_W = (WALKERS > 1) ? $clog2(WALKERS) : 1;
	localparam int LIM_W  = ($clog2(GRID_SIDE + 1) > 6) ? $clog2(GRID_SIDE + 1) : 6;
	localparam int NXY_W  = mwf_pkg::XY_W + 1;

	typedef enum logic [2:0] {
		K_NONE,
		K_FIRST,
		K_MOVED,
		K_STAY,
		K_HOLD
	} kind_t;

	function automatic logic [CELL_W-1:0] cell_idx(input logic [NXY_W-1:0] x,
			input logic [NXY_W-1:0] y);
		return CELL_W'(y) * CELL_W'(GRID_SIDE) + CELL_W'(x);
	endfunction

	// configuration
	logic [4:0] target_x_q;
	logic [4:0] target_y_q;
	logic [5:0] grid_width_q;
	logic [5:0] grid_height_q;
	logic [1:0] start_heading_q;
	logic       cfg_wr;

	// memories
	logic [3:0]         wall_mem [CELLS];
	logic [WALKERS-1:0] vis_mem  [CELLS];
	logic [3:0]         wall_rd_s1;
	logic [WALKERS-1:0] vis_rd_s1;

	// clearing pass
	logic              clearing_q;
	logic [CELL_W-1:0] clr_q;

	// decide stage
	logic               valid_s1;
	logic               phase_s1;
	mwf_pkg::turn_t     item_s1;
	logic               in_fire;
	logic [CELL_W-1:0]  rd_addr;

	// walker state
	mwf_pkg::dir_t      heading_q [WALKERS];
	logic [WALKERS-1:0] started_q;

	// last write into each memory, for a turn whose read raced it
	logic               fwd_wall_ok_q;
	logic [CELL_W-1:0]  fwd_wall_addr_q;
	logic [3:0]         fwd_wall_set_q;
	logic               fwd_vis_ok_q;
	logic [CELL_W-1:0]  fwd_vis_addr_q;
	logic [WALKERS-1:0] fwd_vis_set_q;

	// output register
	logic          out_valid_q;
	mwf_pkg::dir_t out_dir_q;

	// decide logic
	logic [WIDX_W-1:0]  wsel;
	logic [LIM_W-1:0]   gw;
	logic [LIM_W-1:0]   gh;
	logic [CELL_W-1:0]  oc;
	logic [CELL_W-1:0]  nc;
	logic [CELL_W-1:0]  nb_addr;
	logic               nb_ok;
	logic               bad_id;
	logic               oor;
	logic               at_tgt;
	logic               moved;
	kind_t              kind;
	mwf_pkg::dir_t      cur_head;
	mwf_pkg::dir_t      td;
	mwf_pkg::dir_t      new_head;
	logic [3:0]         wall_eff;
	logic [WALKERS-1:0] vis_eff;
	logic               out_free;
	logic               second_pending;
	logic               finish;
	logic               wall_we;
	logic [CELL_W-1:0]  wall_addr;
	logic [3:0]         wall_set;
	logic               vis_we;
	logic [WALKERS-1:0] vis_set;

	// memory write ports, shared with the clearing pass
	logic               mw_wall_we;
	logic [CELL_W-1:0]  mw_wall_addr;
	logic [3:0]         mw_wall_mask;
	logic               mw_vis_we;
	logic [CELL_W-1:0]  mw_vis_addr;
	logic [WALKERS-1:0] mw_vis_mask;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q      <= 5'd5;
			target_y_q      <= 5'd5;
			grid_width_q    <= 6'd32;
			grid_height_q   <= 6'd32;
			start_heading_q <= 2'd1;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				mwf_pkg::REG_TARGET_X:      target_x_q      <= pwdata[4:0];
				mwf_pkg::REG_TARGET_Y:      target_y_q      <= pwdata[4:0];
				mwf_pkg::REG_GRID_WIDTH:    grid_width_q    <= pwdata[5:0];
				mwf_pkg::REG_GRID_HEIGHT:   grid_height_q   <= pwdata[5:0];
				mwf_pkg::REG_START_HEADING: start_heading_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			mwf_pkg::REG_TARGET_X:      prdata = {27'd0, target_x_q};
			mwf_pkg::REG_TARGET_Y:      prdata = {27'd0, target_y_q};
			mwf_pkg::REG_GRID_WIDTH:    prdata = {26'd0, grid_width_q};
			mwf_pkg::REG_GRID_HEIGHT:   prdata = {26'd0, grid_height_q};
			mwf_pkg::REG_START_HEADING: prdata = {30'd0, start_heading_q};
			default:                    prdata = '0;
		endcase
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + CELL_W'(1);
			if (clr_q == CELL_W'(CELLS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// input side
	assign turn.ready = !clearing_q && (!valid_s1 || finish);
	assign in_fire    = turn.valid && turn.ready;
	assign rd_addr    = cell_idx(NXY_W'(turn.cur_x), NXY_W'(turn.cur_y));

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.walker_id <= turn.walker_id;
			item_s1.prev_x    <= turn.prev_x;
			item_s1.prev_y    <= turn.prev_y;
			item_s1.cur_x     <= turn.cur_x;
			item_s1.cur_y     <= turn.cur_y;
			wall_rd_s1        <= wall_mem[rd_addr];
			vis_rd_s1         <= vis_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			if (mw_wall_we && mw_wall_mask[b]) begin
				wall_mem[mw_wall_addr][b] <= !clearing_q;
			end
		end
		for (int b = 0; b < WALKERS; b++) begin
			if (mw_vis_we && mw_vis_mask[b]) begin
				vis_mem[mw_vis_addr][b] <= !clearing_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (finish) begin
				valid_s1 <= 1'b0;
			end
			if (finish) begin
				phase_s1 <= 1'b0;
			end else if (valid_s1 && second_pending) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	// decide stage
	assign wsel     = WIDX_W'(item_s1.walker_id);
	assign gw       = (LIM_W'(grid_width_q) > LIM_W'(GRID_SIDE)) ? LIM_W'(GRID_SIDE)
		: LIM_W'(grid_width_q);
	assign gh       = (LIM_W'(grid_height_q) > LIM_W'(GRID_SIDE)) ? LIM_W'(GRID_SIDE)
		: LIM_W'(grid_height_q);
	assign oc       = cell_idx(NXY_W'(item_s1.prev_x), NXY_W'(item_s1.prev_y));
	assign nc       = cell_idx(NXY_W'(item_s1.cur_x), NXY_W'(item_s1.cur_y));
	assign bad_id   = {3'b000, item_s1.walker_id} >= 5'(WALKERS);
	assign oor      = (LIM_W'(item_s1.prev_x) >= gw) || (LIM_W'(item_s1.cur_x) >= gw)
		|| (LIM_W'(item_s1.prev_y) >= gh) || (LIM_W'(item_s1.cur_y) >= gh);
	assign at_tgt   = (item_s1.cur_x == target_x_q) && (item_s1.cur_y == target_y_q);
	assign moved    = (item_s1.prev_x != item_s1.cur_x) || (item_s1.prev_y != item_s1.cur_y);
	assign cur_head = heading_q[wsel];
	assign td       = mwf_pkg::travel_dir(item_s1.prev_x, item_s1.prev_y,
		item_s1.cur_x, item_s1.cur_y);
	assign wall_eff = wall_rd_s1
		| ((fwd_wall_ok_q && fwd_wall_addr_q == nc) ? fwd_wall_set_q : 4'd0);
	assign vis_eff  = vis_rd_s1
		| ((fwd_vis_ok_q && fwd_vis_addr_q == nc) ? fwd_vis_set_q : '0);

	always_comb begin
		if (bad_id || oor || at_tgt) begin
			kind = K_NONE;
		end else if (!started_q[wsel]) begin
			kind = K_FIRST;
		end else if (moved) begin
			kind = K_MOVED;
		end else if (cur_head != mwf_pkg::DIR_NULL) begin
			kind = K_STAY;
		end else begin
			kind = K_HOLD;
		end
	end

	// the far side of a wall found by a blocked walker, unless it faces the border
	always_comb begin
		nb_ok   = 1'b0;
		nb_addr = oc;
		case (cur_head)
			mwf_pkg::DIR_NORTH: begin
				nb_ok   = item_s1.prev_y != '0;
				nb_addr = cell_idx(NXY_W'(item_s1.prev_x), NXY_W'(item_s1.prev_y) - NXY_W'(1));
			end
			mwf_pkg::DIR_EAST: begin
				nb_ok   = (LIM_W'(item_s1.prev_x) + LIM_W'(1)) < gw;
				nb_addr = cell_idx(NXY_W'(item_s1.prev_x) + NXY_W'(1), NXY_W'(item_s1.prev_y));
			end
			mwf_pkg::DIR_SOUTH: begin
				nb_ok   = (LIM_W'(item_s1.prev_y) + LIM_W'(1)) < gh;
				nb_addr = cell_idx(NXY_W'(item_s1.prev_x), NXY_W'(item_s1.prev_y) + NXY_W'(1));
			end
			mwf_pkg::DIR_WEST: begin
				nb_ok   = item_s1.prev_x != '0;
				nb_addr = cell_idx(NXY_W'(item_s1.prev_x) - NXY_W'(1), NXY_W'(item_s1.prev_y));
			end
			default: ;
		endcase
	end

	assign out_free       = !out_valid_q || move.ready;
	assign second_pending = (kind == K_STAY) && nb_ok && !phase_s1;
	assign finish         = valid_s1 && !second_pending && out_free;

	always_comb begin
		new_head  = mwf_pkg::DIR_NULL;
		wall_we   = 1'b0;
		wall_addr = nc;
		wall_set  = 4'd0;
		vis_we    = 1'b0;
		vis_set   = '0;
		unique case (kind)
			K_FIRST: new_head = mwf_pkg::dir_t'({1'b0, start_heading_q});
			K_MOVED: begin
				vis_we        = finish;
				vis_set[wsel] = 1'b1;
				if (td != mwf_pkg::DIR_NULL) begin
					// stepped back into a cell this walker knows: wall behind it
					if (vis_eff[wsel]) begin
						wall_we = finish;
						wall_set[2'(mwf_pkg::opposite_of(td))] = 1'b1;
					end
					if (!wall_eff[2'(mwf_pkg::left_of(td))]) begin
						new_head = mwf_pkg::left_of(td);
					end else if (!wall_eff[2'(td)]) begin
						new_head = td;
					end else if (!wall_eff[2'(mwf_pkg::right_of(td))]) begin
						new_head = mwf_pkg::right_of(td);
					end else begin
						new_head = mwf_pkg::opposite_of(td);
					end
				end
			end
			K_STAY: begin
				new_head = mwf_pkg::right_of(cur_head);
				if (phase_s1) begin
					wall_addr = nb_addr;
					wall_set[2'(mwf_pkg::opposite_of(cur_head))] = 1'b1;
					wall_we   = finish;
				end else begin
					wall_addr = oc;
					wall_set[2'(cur_head)] = 1'b1;
					wall_we   = valid_s1 && (nb_ok || finish);
				end
			end
			K_HOLD: new_head = mwf_pkg::DIR_NULL;
			K_NONE: new_head = mwf_pkg::DIR_NULL;
			default: new_head = mwf_pkg::DIR_NULL;
		endcase
	end

	assign mw_wall_we   = clearing_q || wall_we;
	assign mw_wall_addr = clearing_q ? clr_q : wall_addr;
	assign mw_wall_mask = clearing_q ? 4'hf : wall_set;
	assign mw_vis_we    = clearing_q || vis_we;
	assign mw_vis_addr  = clearing_q ? clr_q : oc;
	assign mw_vis_mask  = clearing_q ? '1 : vis_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_wall_ok_q <= 1'b0;
			fwd_vis_ok_q  <= 1'b0;
		end else begin
			if (wall_we && !clearing_q) begin
				fwd_wall_ok_q <= 1'b1;
			end
			if (vis_we && !clearing_q) begin
				fwd_vis_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wall_we && !clearing_q) begin
			fwd_wall_addr_q <= wall_addr;
			fwd_wall_set_q  <= wall_set;
		end
		if (vis_we && !clearing_q) begin
			fwd_vis_addr_q <= oc;
			fwd_vis_set_q  <= vis_set;
		end
	end

	// walker headings and started flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
			for (int w = 0; w < WALKERS; w++) begin
				heading_q[w] <= mwf_pkg::DIR_NORTH;
			end
		end else if (finish && kind != K_NONE) begin
			heading_q[wsel] <= new_head;
			if (kind == K_FIRST) begin
				started_q[wsel] <= 1'b1;
			end
		end
	end

	// move register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (move.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_dir_q <= new_head;
		end
	end

	assign move.valid    = out_valid_q;
	assign move.move_dir = out_dir_q;

`ifndef SYNTHESIS
	a_second_phase_is_stay: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && phase_s1 |-> kind == K_STAY)
		else $error("second write phase held by a turn that is not a blocked walker");

	a_second_phase_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && second_pending |=> valid_s1 && phase_s1)
		else $error("neighbor wall write did not follow the first wall write");

	a_finish_shows_move: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> move.valid)
		else $error("finished turn did not reach the move register");

	a_clear_pass_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !move.valid && !wall_we && !vis_we)
		else $error("turn activity during the clearing pass");
`endif

endmodule

[tb/tb_top.sv]
// self-checking bench for the wall follower: directed table, random maze walks, apb settings
module tb_top;
	import mwf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SIDE        = GRID_SIDE_DEF;
	localparam int CELL_COUNT  = SIDE * SIDE;
	localparam int PHASES      = 10;
	localparam int PHASE_TURNS = 100;

	typedef struct packed {
		logic        is_cfg;
		reg_idx_t    ridx;
		logic [31:0] val;
		turn_t       t;
		logic        typed;
		dir_t        want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	mwf_turn_if turn_ch();
	mwf_move_if move_ch();

	maze_wall_follower_step_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.turn    (turn_ch),
		.move    (move_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the block's map and walker state
	logic [3:0]       wall_map [CELL_COUNT];
	logic [3:0]       visit_map [CELL_COUNT];
	dir_t             heading [WALKERS_DEF];
	logic             started [WALKERS_DEF];
	logic [4:0]       cfg_tx;
	logic [4:0]       cfg_ty;
	logic [5:0]       cfg_gw;
	logic [5:0]       cfg_gh;
	logic [1:0]       cfg_sh;

	// walkers' true positions in a hidden maze, and the move each was last told
	logic [3:0]       maze_wall [CELL_COUNT];
	logic [XY_W-1:0]  pos_x [WALKERS_DEF];
	logic [XY_W-1:0]  pos_y [WALKERS_DEF];
	dir_t             last_move [WALKERS_DEF];

	dir_t             moves_due[$];
	plan_row_t        plan[$];
	int               errors = 0;
	int               cycle_count = 0;
	int               send_idle_pct = 0;
	int               stall_pct = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic dir_t turn_left(input dir_t d);
		case (d)
			DIR_WEST:  return DIR_SOUTH;
			DIR_NORTH: return DIR_WEST;
			DIR_SOUTH: return DIR_EAST;
			DIR_EAST:  return DIR_NORTH;
			default:   return DIR_NULL;
		endcase
	endfunction

	function automatic dir_t turn_right(input dir_t d);
		case (d)
			DIR_WEST:  return DIR_NORTH;
			DIR_NORTH: return DIR_EAST;
			DIR_SOUTH: return DIR_WEST;
			DIR_EAST:  return DIR_SOUTH;
			default:   return DIR_NULL;
		endcase
	endfunction

	function automatic dir_t reverse(input dir_t d);
		case (d)
			DIR_WEST:  return DIR_EAST;
			DIR_NORTH: return DIR_SOUTH;
			DIR_SOUTH: return DIR_NORTH;
			DIR_EAST:  return DIR_WEST;
			default:   return DIR_NULL;
		endcase
	endfunction

	function automatic int unsigned side_in_use(input logic [5:0] v);
		return (v > SIDE) ? SIDE : 32'(v);
	endfunction

	function automatic int unsigned cell_at(input int unsigned x, input int unsigned y);
		return (y * SIDE + x) % CELL_COUNT;
	endfunction

	// next move for one turn; updates the mirrored map and walker state
	function automatic dir_t next_move(input turn_t t);
		int unsigned gw;
		int unsigned gh;
		int unsigned oc;
		int unsigned nc;
		dir_t head;
		dir_t lft;
		dir_t rgt;
		gw = side_in_use(cfg_gw);
		gh = side_in_use(cfg_gh);
		if (t.prev_x >= gw || t.cur_x >= gw || t.prev_y >= gh || t.cur_y >= gh) begin
			return DIR_NULL;
		end
		if (t.cur_x == cfg_tx && t.cur_y == cfg_ty) begin
			return DIR_NULL;
		end
		if (!started[t.walker_id]) begin
			started[t.walker_id] = 1'b1;
			heading[t.walker_id] = dir_t'({1'b0, cfg_sh});
			return heading[t.walker_id];
		end
		head = heading[t.walker_id];
		oc = cell_at(t.prev_x, t.prev_y);
		nc = cell_at(t.cur_x, t.cur_y);
		if (t.prev_x != t.cur_x || t.prev_y != t.cur_y) begin
			if (t.cur_y == t.prev_y && t.cur_x < t.prev_x) begin
				head = DIR_WEST;
			end else if (t.cur_x == t.prev_x && t.cur_y < t.prev_y) begin
				head = DIR_NORTH;
			end else if (t.cur_x == t.prev_x && t.cur_y > t.prev_y) begin
				head = DIR_SOUTH;
			end else if (t.cur_y == t.prev_y && t.cur_x > t.prev_x) begin
				head = DIR_EAST;
			end else begin
				head = DIR_NULL;
			end
			visit_map[oc][t.walker_id] = 1'b1;
			if (head != DIR_NULL) begin
				lft = turn_left(head);
				rgt = turn_right(head);
				// stepping back into a visited cell walls off the way behind
				if (visit_map[nc][t.walker_id]) begin
					wall_map[nc][reverse(head)] = 1'b1;
				end
				if (!wall_map[nc][lft]) begin
					head = lft;
				end else if (!wall_map[nc][head]) begin
					head = head;
				end else if (!wall_map[nc][rgt]) begin
					head = rgt;
				end else begin
					head = reverse(head);
				end
			end
		end else if (head != DIR_NULL) begin
			// bumped: wall in this cell and, inside the grid, in the neighbor
			wall_map[oc][head] = 1'b1;
			case (head)
				DIR_NORTH: begin
					if (t.prev_y != 0) wall_map[cell_at(t.prev_x, t.prev_y - 1)][DIR_SOUTH] = 1'b1;
				end
				DIR_EAST: begin
					if (t.prev_x + 1 < gw) wall_map[cell_at(t.prev_x + 1, t.prev_y)][DIR_WEST] = 1'b1;
				end
				DIR_SOUTH: begin
					if (t.prev_y + 1 < gh) wall_map[cell_at(t.prev_x, t.prev_y + 1)][DIR_NORTH] = 1'b1;
				end
				default: begin
					if (t.prev_x != 0) wall_map[cell_at(t.prev_x - 1, t.prev_y)][DIR_EAST] = 1'b1;
				end
			endcase
			head = turn_right(head);
		end else begin
			head = DIR_NULL;
		end
		heading[t.walker_id] = head;
		return head;
	endfunction

	function automatic logic [XY_W-1:0] rand_coord(input int unsigned lim);
		return (lim == 0) ? XY_W'($urandom_range(0, SIDE - 1))
			: XY_W'($urandom_range(0, lim - 1));
	endfunction

	// mostly walks that obey the returned move in the hidden maze, plus jumps and noise
	function automatic turn_t walk_turn(input logic [WID_W-1:0] w);
		turn_t t;
		int unsigned gw;
		int unsigned gh;
		int unsigned r;
		logic [XY_W-1:0] nx;
		logic [XY_W-1:0] ny;
		logic open;
		gw = side_in_use(cfg_gw);
		gh = side_in_use(cfg_gh);
		r = $urandom_range(0, 99);
		t.walker_id = w;
		t.prev_x = pos_x[w];
		t.prev_y = pos_y[w];
		nx = pos_x[w];
		ny = pos_y[w];
		if (pos_x[w] >= gw || pos_y[w] >= gh) begin
			nx = rand_coord(gw);
			ny = rand_coord(gh);
			t.prev_x = nx;
			t.prev_y = ny;
		end else if (r < 8) begin
			t.prev_x = XY_W'($urandom_range(0, SIDE - 1));
			t.prev_y = XY_W'($urandom_range(0, SIDE - 1));
			nx = XY_W'($urandom_range(0, SIDE - 1));
			ny = XY_W'($urandom_range(0, SIDE - 1));
		end else if (r < 14) begin
			nx = rand_coord(gw);
			ny = rand_coord(gh);
		end else if (r < 22 || last_move[w] == DIR_NULL) begin
			// straight jump gives the walker a heading again
			if ($urandom_range(0, 1)) begin
				nx = rand_coord(gw);
			end else begin
				ny = rand_coord(gh);
			end
		end else begin
			open = !maze_wall[cell_at(nx, ny)][last_move[w]];
			case (last_move[w])
				DIR_WEST: begin
					if (open && nx != 0) nx = nx - XY_W'(1);
				end
				DIR_NORTH: begin
					if (open && ny != 0) ny = ny - XY_W'(1);
				end
				DIR_SOUTH: begin
					if (open && ny + 1 < gh) ny = ny + XY_W'(1);
				end
				default: begin
					if (open && nx + 1 < gw) nx = nx + XY_W'(1);
				end
			endcase
		end
		t.cur_x = nx;
		t.cur_y = ny;
		pos_x[w] = nx;
		pos_y[w] = ny;
		return t;
	endfunction

	task automatic send_turn(input turn_t t, input logic typed, input dir_t fixed);
		int gap;
		dir_t pred;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			turn_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		turn_ch.valid     <= 1'b1;
		turn_ch.walker_id <= t.walker_id;
		turn_ch.prev_x    <= t.prev_x;
		turn_ch.prev_y    <= t.prev_y;
		turn_ch.cur_x     <= t.cur_x;
		turn_ch.cur_y     <= t.cur_y;
		@(posedge clk);
		while (!turn_ch.ready) @(posedge clk);
		pred = next_move(t);
		moves_due.push_back(typed ? fixed : pred);
		last_move[t.walker_id] = pred;
	endtask

	// block is idle once every move is out
	task automatic wait_idle();
		turn_ch.valid <= 1'b0;
		@(posedge clk);
		while (moves_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_TARGET_X:    cfg_tx = val[4:0];
			REG_TARGET_Y:    cfg_ty = val[4:0];
			REG_GRID_WIDTH:  cfg_gw = val[5:0];
			REG_GRID_HEIGHT: cfg_gh = val[5:0];
			default:         cfg_sh = val[1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input int tx, input int ty, input int gw, input int gh,
			input int sh);
		wait_idle();
		apb_write(REG_TARGET_X, tx);
		apb_write(REG_TARGET_Y, ty);
		apb_write(REG_GRID_WIDTH, gw);
		apb_write(REG_GRID_HEIGHT, gh);
		apb_write(REG_START_HEADING, sh);
	endtask

	task automatic add_turn(input int w, input int px, input int py, input int cx, input int cy,
			input logic typed, input dir_t want);
		plan_row_t row;
		row = '0;
		row.t.walker_id = WID_W'(w);
		row.t.prev_x = XY_W'(px);
		row.t.prev_y = XY_W'(py);
		row.t.cur_x = XY_W'(cx);
		row.t.cur_y = XY_W'(cy);
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic add_cfg(input reg_idx_t idx, input logic [31:0] val);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.ridx = idx;
		row.val = val;
		plan.push_back(row);
	endtask

	// move channel: check each transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && move_ch.valid && move_ch.ready) begin
			if (moves_due.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: move_dir expected none actual %0d", $time, move_ch.move_dir);
			end else if (move_ch.move_dir !== moves_due[0]) begin
				errors <= errors + 1;
				$display("%0t: move_dir expected %0d actual %0d", $time, moves_due[0],
					move_ch.move_dir);
				void'(moves_due.pop_front());
			end else begin
				void'(moves_due.pop_front());
			end
		end
		move_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int ph;
		int i;
		turn_t t;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		turn_ch.valid     = 1'b0;
		turn_ch.walker_id = '0;
		turn_ch.prev_x    = '0;
		turn_ch.prev_y    = '0;
		turn_ch.cur_x     = '0;
		turn_ch.cur_y     = '0;
		cfg_tx = 5'd5;
		cfg_ty = 5'd5;
		cfg_gw = 6'd32;
		cfg_gh = 6'd32;
		cfg_sh = 2'd1;
		for (i = 0; i < CELL_COUNT; i++) begin
			wall_map[i]  = '0;
			visit_map[i] = '0;
			maze_wall[i] = {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
				$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
		end
		for (i = 0; i < WALKERS_DEF; i++) begin
			started[i]   = 1'b0;
			heading[i]   = DIR_NORTH;
			pos_x[i]     = XY_W'($urandom_range(0, SIDE - 1));
			pos_y[i]     = XY_W'($urandom_range(0, SIDE - 1));
			last_move[i] = DIR_NULL;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset settings: target (5,5), full grid, start heading north
		add_turn(0, 0, 0, 0, 0, 1, DIR_NORTH);   // first turn returns start heading
		add_turn(0, 0, 0, 0, 0, 1, DIR_EAST);    // bump north at the top edge, turn right
		add_turn(0, 0, 0, 1, 0, 1, DIR_NORTH);   // moved east, left is open
		add_turn(0, 1, 0, 1, 0, 1, DIR_EAST);
		add_turn(0, 1, 0, 0, 0, 0, DIR_NULL);    // back into a visited cell
		add_turn(0, 0, 0, 0, 0, 0, DIR_NULL);
		add_turn(0, 0, 0, 0, 0, 0, DIR_NULL);
		add_turn(0, 1, 0, 0, 0, 0, DIR_NULL);    // all four sides walled, turn back
		add_turn(0, 0, 0, 1, 1, 1, DIR_NULL);    // diagonal jump loses the heading
		add_turn(0, 1, 1, 1, 1, 1, DIR_NULL);    // still null while standing
		add_turn(0, 1, 1, 1, 4, 0, DIR_NULL);    // long straight jump restores it
		add_turn(1, 5, 4, 5, 5, 1, DIR_NULL);    // at target, stays not started
		add_turn(1, 3, 3, 3, 3, 1, DIR_NORTH);
		add_turn(2, 31, 31, 31, 31, 1, DIR_NORTH);
		add_turn(2, 31, 31, 31, 31, 1, DIR_EAST);
		add_turn(2, 31, 31, 31, 31, 1, DIR_SOUTH);
		add_turn(2, 31, 31, 31, 31, 1, DIR_WEST);
		add_turn(2, 31, 31, 31, 31, 1, DIR_NORTH);
		add_turn(2, 31, 31, 0, 31, 0, DIR_NULL);
		add_cfg(REG_START_HEADING, 3);
		add_turn(3, 2, 2, 2, 2, 1, DIR_EAST);
		add_cfg(REG_GRID_WIDTH, 4);
		add_turn(3, 2, 2, 9, 2, 1, DIR_NULL);    // cell outside the grid
		add_cfg(REG_GRID_HEIGHT, 1);
		add_turn(3, 2, 0, 2, 0, 0, DIR_NULL);
		add_turn(3, 2, 1, 2, 1, 1, DIR_NULL);
		add_cfg(REG_GRID_WIDTH, 0);
		add_turn(3, 0, 0, 0, 0, 1, DIR_NULL);    // zero width, nothing in range
		add_cfg(REG_GRID_WIDTH, 63);
		add_cfg(REG_GRID_HEIGHT, 63);
		add_turn(3, 31, 2, 31, 2, 0, DIR_NULL);
		add_cfg(REG_TARGET_X, 31);
		add_cfg(REG_TARGET_Y, 31);
		add_turn(2, 30, 31, 31, 31, 1, DIR_NULL);
		add_cfg(REG_TARGET_X, 0);
		add_cfg(REG_TARGET_Y, 0);
		add_turn(3, 1, 0, 0, 0, 1, DIR_NULL);

		send_idle_pct = 14;
		stall_pct     = 14;
		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				wait_idle();
				apb_write(plan[k].ridx, plan[k].val);
			end else begin
				send_turn(plan[k].t, plan[k].typed, plan[k].want);
			end
		end

		// random walks under a series of settings and idling patterns
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_setting(5, 5, 32, 32, 1);
				1: apply_setting(3, 2, 4, 4, 0);
				2: apply_setting(7, 0, 8, 6, 2);
				3: apply_setting(31, 31, 32, 32, 3);
				4: apply_setting(0, 1, 1, 1, 2);
				5: apply_setting(2, 9, 3, 12, 0);
				6: apply_setting(15, 15, 63, 40, 3);
				7: apply_setting(4, 4, 0, 32, 1);
				8: apply_setting(6, 1, 16, 2, 2);
				default: apply_setting(10, 20, 32, 32, 1);
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 85;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 85;
				end
				default: begin
					send_idle_pct = 14;
					stall_pct     = 14;
				end
			endcase
			for (i = 0; i < PHASE_TURNS; i++) begin
				t = walk_turn(WID_W'($urandom_range(0, WALKERS_DEF - 1)));
				send_turn(t, 1'b0, DIR_NULL);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && moves_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
